// ----- sv/hwrg_pkg.sv -----
package hwrg_pkg;

    // Width of every pixel field
    localparam int unsigned PixW = 8;

    // Breakpoint levels: floor(b*671/1000) and floor(b*333/1000) by reciprocal.
    // For an 8-bit b the rounded-up constants at a 2^-20 scale are exact.
    localparam int unsigned LvlShift = 20;
    localparam int unsigned LvlProdW = PixW + LvlShift;
    localparam logic [LvlShift-1:0] MulA = 20'd703595;
    localparam logic [LvlShift-1:0] MulC = 20'd349176;

    // Segment geometry: eight segments, 32 wide, the last one 31 wide
    localparam int unsigned SegW    = 3;
    localparam int unsigned OffW    = PixW - SegW;
    localparam logic [SegW-1:0] LastSeg = 3'd7;

    // Interpolation product t * |hi - lo| and its division
    localparam int unsigned ProdW     = OffW + PixW;
    localparam int unsigned RecShift  = 20;
    localparam int unsigned RecW      = 16;
    localparam logic [RecW-1:0] Rec31 = 16'd33826;
    localparam int unsigned RecProdW  = ProdW + RecW;

    typedef enum logic [1:0] {
        LV_F,
        LV_A,
        LV_C,
        LV_Z
    } t_level_kind;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    // Per-stage advance strobes for the interpolation pipe
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_hwrg_adv;

    // Level kind at breakpoint idx of a channel
    function automatic t_level_kind kind_of(input t_chan chan, input logic [SegW:0] idx);
        t_level_kind k;
        k = LV_Z;
        case (chan)
            CH_RED: begin
                case (idx)
                    4'd0, 4'd8:       k = LV_F;
                    4'd1, 4'd2, 4'd7: k = LV_A;
                    4'd6:             k = LV_C;
                    default:          k = LV_Z;
                endcase
            end
            CH_GREEN: begin
                case (idx)
                    4'd1:       k = LV_C;
                    4'd2, 4'd4: k = LV_A;
                    4'd3:       k = LV_F;
                    default:    k = LV_Z;
                endcase
            end
            CH_BLUE: begin
                case (idx)
                    4'd4, 4'd7: k = LV_C;
                    4'd5:       k = LV_F;
                    4'd6:       k = LV_A;
                    default:    k = LV_Z;
                endcase
            end
            default: k = LV_Z;
        endcase
        return k;
    endfunction

    // Turn a level kind into its value
    function automatic logic [PixW-1:0] level_pick(
        input t_level_kind kind,
        input logic [PixW-1:0] f,
        input logic [PixW-1:0] a,
        input logic [PixW-1:0] c
    );
        logic [PixW-1:0] v;
        v = '0;
        case (kind)
            LV_F:    v = f;
            LV_A:    v = a;
            LV_C:    v = c;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/hwrg_in_if.sv -----
interface hwrg_in_if
    import hwrg_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [PixW-1:0] hue;
    logic [PixW-1:0] level;

    modport source (output valid, output hue, output level, input ready);
    modport sink   (input valid, input hue, input level, output ready);
endinterface

// ----- sv/hwrg_out_if.sv -----
interface hwrg_out_if
    import hwrg_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [PixW-1:0] first_slot;
    logic [PixW-1:0] second_slot;
    logic [PixW-1:0] blue_out;

    modport source (output valid, output first_slot, output second_slot, output blue_out,
                    input ready);
    modport sink   (input valid, input first_slot, input second_slot, input blue_out,
                    output ready);
endinterface

// ----- sv/hue_wheel_rgb_generator_core.sv -----
// Hue wheel color generator.
// Input channel i_pix carries a hue position and a brightness level per word;
// output channel o_pix carries one color word per input word: blue_out plus
// two slots holding red and green, swapped when the color order bit is set.
// i_cfg_we / i_cfg_wdata write the color order bit; change it only while no
// word is in flight, since it is applied at the output.
// An accepted word passes through the stage registers in order before it is
// presented on o_pix.
// Throughput: one word per cycle while o_pix.ready is high. The pipe is six
// register stages: brightness multiply, level shaping, endpoint select, offset
// multiply, segment divide and final add; each stage holds one word.
// Stall: each stage holds its word while the next one is full and blocked, so
// a stalled receiver fills the pipe before i_pix.ready drops; bubbles are
// squeezed out, no word is lost or repeated.
// Reset (synchronous, active low): empties the pipe, holds i_pix.ready low and
// clears the color order bit to red then green.
module hue_wheel_rgb_generator_core
    import hwrg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    hwrg_in_if.sink   i_pix,
    hwrg_out_if.source o_pix
);

    // Color order register
    logic r_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    // Stage valids and advance chain: a stage loads when empty or draining
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic e1, e2, e3, e4, e5, e6;
    t_hwrg_adv adv;

    assign e6 = !r_v6 || o_pix.ready;
    assign e5 = !r_v5 || e6;
    assign e4 = !r_v4 || e5;
    assign e3 = !r_v3 || e4;
    assign e2 = !r_v2 || e3;
    assign e1 = !r_v1 || e2;

    assign adv.s3 = e3;
    assign adv.s4 = e4;
    assign adv.s5 = e5;
    assign adv.s6 = e6;

    // Refuse words while reset is held
    assign i_pix.ready = e1 && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (e1) r_v1 <= i_pix.valid;
            if (e2) r_v2 <= r_v1;
            if (e3) r_v3 <= r_v2;
            if (e4) r_v4 <= r_v3;
            if (e5) r_v5 <= r_v4;
            if (e6) r_v6 <= r_v5;
        end
    end

    // Stage 1: scale brightness by both reciprocal constants
    logic [PixW-1:0]     r1_hue, r1_level;
    logic [LvlProdW-1:0] r1_pa, r1_pc;

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r1_hue   <= i_pix.hue;
            r1_level <= i_pix.level;
            r1_pa    <= LvlProdW'(i_pix.level) * LvlProdW'(MulA);
            r1_pc    <= LvlProdW'(i_pix.level) * LvlProdW'(MulC);
        end
    end

    // Stage 2: breakpoint levels, segment and offset within it
    logic [PixW-1:0] r2_f, r2_a, r2_c;
    logic [SegW-1:0] r2_seg;
    logic [OffW-1:0] r2_off;

    always_ff @(posedge i_clk) begin
        if (e2) begin
            r2_f   <= r1_level;
            r2_a   <= r1_pa[LvlShift +: PixW];
            r2_c   <= r1_pc[LvlShift +: PixW];
            r2_seg <= r1_hue[PixW-1 -: SegW];
            r2_off <= r1_hue[OffW-1:0];
        end
    end

    // Stages 3 to 6: one interpolator per channel
    logic [PixW-1:0] red_val, green_val, blue_val;

    hwrg_lerp u_lerp_red (
        .i_clk   (i_clk),
        .i_chan  (CH_RED),
        .i_adv   (adv),
        .i_lvl_f (r2_f),
        .i_lvl_a (r2_a),
        .i_lvl_c (r2_c),
        .i_seg   (r2_seg),
        .i_off   (r2_off),
        .o_val   (red_val)
    );

    hwrg_lerp u_lerp_green (
        .i_clk   (i_clk),
        .i_chan  (CH_GREEN),
        .i_adv   (adv),
        .i_lvl_f (r2_f),
        .i_lvl_a (r2_a),
        .i_lvl_c (r2_c),
        .i_seg   (r2_seg),
        .i_off   (r2_off),
        .o_val   (green_val)
    );

    hwrg_lerp u_lerp_blue (
        .i_clk   (i_clk),
        .i_chan  (CH_BLUE),
        .i_adv   (adv),
        .i_lvl_f (r2_f),
        .i_lvl_a (r2_a),
        .i_lvl_c (r2_c),
        .i_seg   (r2_seg),
        .i_off   (r2_off),
        .o_val   (blue_val)
    );

    // Present the word, slots ordered by the color order bit
    assign o_pix.valid       = r_v6;
    assign o_pix.first_slot  = r_order ? green_val : red_val;
    assign o_pix.second_slot = r_order ? red_val : green_val;
    assign o_pix.blue_out    = blue_val;

endmodule

// ----- sv/hwrg_lerp.sv -----
module hwrg_lerp
    import hwrg_pkg::*;
(
    input  logic            i_clk,
    input  t_chan           i_chan,
    input  t_hwrg_adv       i_adv,
    input  logic [PixW-1:0] i_lvl_f,
    input  logic [PixW-1:0] i_lvl_a,
    input  logic [PixW-1:0] i_lvl_c,
    input  logic [SegW-1:0] i_seg,
    input  logic [OffW-1:0] i_off,
    output logic [PixW-1:0] o_val
);

    // Stage 3: endpoints, difference as sign and magnitude
    logic [PixW-1:0] n_lo, n_hi;
    logic            n_neg;
    logic [PixW-1:0] n_mag;
    logic [PixW-1:0] r3_lo, r3_mag;
    logic            r3_neg, r3_last;
    logic [OffW-1:0] r3_off;

    always_comb begin
        n_lo  = level_pick(kind_of(i_chan, {1'b0, i_seg}), i_lvl_f, i_lvl_a, i_lvl_c);
        n_hi  = level_pick(kind_of(i_chan, {1'b0, i_seg} + 4'd1), i_lvl_f, i_lvl_a, i_lvl_c);
        n_neg = (n_hi < n_lo);
        n_mag = n_neg ? (n_lo - n_hi) : (n_hi - n_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r3_lo   <= n_lo;
            r3_mag  <= n_mag;
            r3_neg  <= n_neg;
            r3_off  <= i_off;
            r3_last <= (i_seg == LastSeg);
        end
    end

    // Stage 4: offset times magnitude
    logic [ProdW-1:0] r4_prod;
    logic [PixW-1:0]  r4_lo;
    logic             r4_neg, r4_last;

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r4_prod <= ProdW'(r3_off) * ProdW'(r3_mag);
            r4_lo   <= r3_lo;
            r4_neg  <= r3_neg;
            r4_last <= r3_last;
        end
    end

    // Stage 5: divide by segment width, 32 by shift, 31 by reciprocal
    logic [RecProdW-1:0] n_rec;
    logic [PixW-1:0]     n_quo;
    logic [PixW-1:0]     r5_quo, r5_lo;
    logic                r5_neg;

    always_comb begin
        n_rec = RecProdW'(r4_prod) * RecProdW'(Rec31);
        if (r4_last) begin
            n_quo = n_rec[RecShift +: PixW];
        end else begin
            n_quo = r4_prod[OffW +: PixW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s5) begin
            r5_quo <= n_quo;
            r5_lo  <= r4_lo;
            r5_neg <= r4_neg;
        end
    end

    // Stage 6: apply the truncated step to the low endpoint
    logic [PixW-1:0] r6_val;

    always_ff @(posedge i_clk) begin
        if (i_adv.s6) begin
            r6_val <= r5_neg ? (r5_lo - r5_quo) : (r5_lo + r5_quo);
        end
    end

    assign o_val = r6_val;

endmodule

// ----- tb/sv/testbench.sv -----
module testbench
    import hwrg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned StallLimit = 4000;
    localparam int unsigned IdlePct    = 27;

    typedef struct packed {
        logic [PixW-1:0] first_slot;
        logic [PixW-1:0] second_slot;
        logic [PixW-1:0] blue_out;
    } t_color_word;

    // Predict color words from accepted hue/level words and check the output stream
    class hue_color_tracker;
        t_level_kind wheel[3][9];
        bit          swap_rg;
        t_color_word expected_colors[$];
        int unsigned mismatches;
        int unsigned pixels_in;
        int unsigned colors_out;

        function new();
            wheel[CH_RED]   = '{LV_F, LV_A, LV_A, LV_Z, LV_Z, LV_Z, LV_C, LV_A, LV_F};
            wheel[CH_GREEN] = '{LV_Z, LV_C, LV_A, LV_F, LV_A, LV_Z, LV_Z, LV_Z, LV_Z};
            wheel[CH_BLUE]  = '{LV_Z, LV_Z, LV_Z, LV_Z, LV_C, LV_F, LV_A, LV_C, LV_Z};
            swap_rg    = 1'b0;
            mismatches = 0;
            pixels_in  = 0;
            colors_out = 0;
        endfunction

        function int level_value(t_level_kind kind, int b);
            case (kind)
                LV_F:    return b;
                LV_A:    return (b * 671) / 1000;
                LV_C:    return (b * 333) / 1000;
                default: return 0;
            endcase
        endfunction

        // Interpolate one channel inside its segment; division truncates toward zero
        function logic [PixW-1:0] ramp(t_chan ch, int seg, int hue, int b);
            int lo;
            int hi;
            int x0;
            int x1;
            int v;
            lo = level_value(wheel[ch][seg], b);
            hi = level_value(wheel[ch][seg + 1], b);
            x0 = seg * 32;
            x1 = (seg == 7) ? 255 : x0 + 32;
            v  = (hue - x0) * (hi - lo) / (x1 - x0) + lo;
            return PixW'(v);
        endfunction

        function t_color_word predict_color(logic [PixW-1:0] hue, logic [PixW-1:0] level);
            t_color_word     w;
            int              seg;
            logic [PixW-1:0] r;
            logic [PixW-1:0] g;
            seg = int'(hue) >> 5;
            r   = ramp(CH_RED, seg, int'(hue), int'(level));
            g   = ramp(CH_GREEN, seg, int'(hue), int'(level));
            w.blue_out    = ramp(CH_BLUE, seg, int'(hue), int'(level));
            w.first_slot  = swap_rg ? g : r;
            w.second_slot = swap_rg ? r : g;
            return w;
        endfunction

        function void note_pixel(logic [PixW-1:0] hue, logic [PixW-1:0] level);
            expected_colors.push_back(predict_color(hue, level));
            pixels_in++;
        endfunction

        function void check_color(t_color_word got);
            t_color_word want;
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected color word first %0d second %0d blue %0d",
                         $time, got.first_slot, got.second_slot, got.blue_out);
                mismatches++;
                return;
            end
            want = expected_colors.pop_front();
            colors_out++;
            if (got.first_slot !== want.first_slot) begin
                $display("%0t: first_slot expected %0d actual %0d",
                         $time, want.first_slot, got.first_slot);
                mismatches++;
            end
            if (got.second_slot !== want.second_slot) begin
                $display("%0t: second_slot expected %0d actual %0d",
                         $time, want.second_slot, got.second_slot);
                mismatches++;
            end
            if (got.blue_out !== want.blue_out) begin
                $display("%0t: blue_out expected %0d actual %0d",
                         $time, want.blue_out, got.blue_out);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_colors.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    bit   calm;
    int unsigned quiet_cycles;
    int unsigned order_writes;
    hue_color_tracker tracker = new();

    hwrg_in_if  pix_in ();
    hwrg_out_if pix_out ();

    hue_wheel_rgb_generator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        pix_in.valid  = 1'b0;
        pix_in.hue    = '0;
        pix_in.level  = '0;
        pix_out.ready = 1'b0;
        calm          = 1'b0;
        quiet_cycles  = 0;
        order_writes  = 0;
    end

    always #5 i_clk = ~i_clk;

    // Stall the output side at random, except during the calm stretch
    always @(posedge i_clk) begin
        pix_out.ready <= calm || ($urandom_range(99) >= IdlePct);
    end

    // Record accepted words on both channels and guard against a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_in.valid && pix_in.ready) begin
                tracker.note_pixel(pix_in.hue, pix_in.level);
            end
            if (pix_out.valid && pix_out.ready) begin
                tracker.check_color('{pix_out.first_slot, pix_out.second_slot,
                                      pix_out.blue_out});
            end
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= StallLimit) begin
                $display("%0t: no progress for %0d cycles", $time, StallLimit);
                $display("testbench NOT OK");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one word, with random idle cycles ahead of it, and hold it until taken
    task automatic send_pixel(input logic [PixW-1:0] hue, input logic [PixW-1:0] level);
        while (!calm && ($urandom_range(99) < IdlePct)) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.hue   <= hue;
        pix_in.level <= level;
        do @(posedge i_clk); while (!pix_in.ready);
    endtask

    // Drain every word in flight, then change the color order
    task automatic set_color_order(input logic order);
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= order;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        tracker.swap_rg = order;
        order_writes++;
    endtask

    // Random words, weighted toward breakpoints and brightness extremes
    task automatic send_random(input int unsigned count);
        logic [PixW-1:0] hue;
        logic [PixW-1:0] level;
        int unsigned     k;
        repeat (count) begin
            if ($urandom_range(7) == 0) begin
                k   = $urandom_range(8);
                hue = (k == 8) ? 8'd255 : PixW'(k * 32 + $urandom_range(2) - 1);
            end else begin
                hue = PixW'($urandom_range(255));
            end
            case ($urandom_range(9))
                0:       level = 8'd0;
                1:       level = 8'd255;
                default: level = PixW'($urandom_range(255));
            endcase
            send_pixel(hue, level);
        end
    endtask

    initial begin
        logic [PixW-1:0] bounds[17];
        bounds = '{8'd0, 8'd31, 8'd32, 8'd63, 8'd64, 8'd95, 8'd96, 8'd127, 8'd128,
                   8'd159, 8'd160, 8'd191, 8'd192, 8'd223, 8'd224, 8'd254, 8'd255};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: segment edges at full brightness, then brightness extremes and assorted mid-range levels
        set_color_order(1'b0);
        foreach (bounds[i]) send_pixel(bounds[i], 8'd255);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd100, 8'd1);
        send_pixel(8'd16, 8'd128);
        send_pixel(8'd200, 8'd3);
        send_pixel(8'd240, 8'd77);
        send_pixel(8'd170, 8'd200);
        send_pixel(8'd128, 8'd170);

        // Random phases across both color orders, one without any idling
        set_color_order(1'b1);
        send_pixel(8'd40, 8'd255);
        send_random(300);
        set_color_order(1'b0);
        calm = 1'b1;
        send_random(300);
        calm = 1'b0;
        set_color_order(1'b1);
        send_random(500);

        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("Sent %0d hue/level words, checked %0d color words, %0d order writes.",
                 tracker.pixels_in, tracker.colors_out, order_writes);
        $display("Covered segment edges, brightness extremes, both slot orders, stalls.");
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
